FILE: rtl/dad_pkg.sv
// Shared types and constants for the detector anchor decode block.
// No dependencies; imported by every module under rtl/ except dad_out_queue.
package dad_pkg;

  localparam int MaxClasses = 128;
  localparam int OutDepth   = 4;

  localparam logic [7:0] FIRST_CLASS_POS = 8'd5;
  localparam logic [7:0] POS_MAX         = 8'd255;

  localparam logic signed [31:0] SCORE_INIT = 32'shFFFF_0000;

  localparam int SCALE_W    = 24;
  localparam int DIFF_W     = 36;
  localparam int MAG_W      = DIFF_W - 1;
  localparam int LO_W       = 17;
  localparam int HI_W       = MAG_W - LO_W;
  localparam int SUM_W      = MAG_W + SCALE_W;
  localparam int MAP_SHIFT  = 33;
  localparam int QUOT_W     = SUM_W - MAP_SHIFT;
  localparam int CORNER_W   = QUOT_W + 1;
  localparam int OUT_DATA_W = 112;

  typedef enum logic [2:0] {
    REG_SCORE_THRESHOLD = 3'd0,
    REG_MIN_BOX_SIZE    = 3'd1,
    REG_MAX_BOX_SIZE    = 3'd2,
    REG_MAP_SCALE       = 3'd3,
    REG_PAD_X           = 3'd4,
    REG_PAD_Y           = 3'd5,
    REG_IMAGE_WIDTH     = 3'd6,
    REG_IMAGE_HEIGHT    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [16:0]        score_threshold;
    logic [30:0]        min_box_size;
    logic [30:0]        max_box_size;
    logic [23:0]        map_scale;
    logic signed [31:0] pad_x;
    logic signed [31:0] pad_y;
    logic [13:0]        image_width;
    logic [13:0]        image_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    score_threshold: 17'd16384,
    min_box_size:    31'd131072,
    max_box_size:    31'd268435456,
    map_scale:       24'd65536,
    pad_x:           32'sd0,
    pad_y:           32'sd0,
    image_width:     14'd640,
    image_height:    14'd640
  };

  typedef struct packed {
    logic               valid;
    logic               emit;
    logic [6:0]         class_index;
    logic signed [31:0] score;
  } row_end_t;

endpackage

FILE: rtl/detector_anchor_decode.sv
// Detector anchor decode top level: config registers, corner clamping,
// output queue. Depends on dad_pkg, dad_row_accum, dad_corner_map, dad_out_queue.
//
// Takes one prediction element per cycle while s_axis_tready is high (cx, cy, w, h,
// objectness, class scores; tlast on the last score) and emits at most one detection per row.
// The element path is fully pipelined: one word per clock while s_axis_tready is high. A
// detection is written to the output queue after its row's last word passes the capture
// register, product stage, best stage, three register stages of the corner mapping and clamp.
// The queue holds OUT_DEPTH detections; s_axis_tready drops only while
// OUT_DEPTH closed rows are still awaiting their decision or delivery.
module detector_anchor_decode import dad_pkg::*; #(
  parameter int OUT_DEPTH = OutDepth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // [31:0] value
  input  logic                  s_axis_tlast,  // last_in_row
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] left, [31:16] top, [48:32] right, [65:49] bottom,
  // [72:66] class_index, [104:73] score, [111:105] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  cfg_t       cfg;
  row_end_t   row_end;
  logic       accept, end_accept, drop, pop;
  logic [CNT_W-1:0] pending;
  logic signed [DIFF_W-1:0]   diff_x1, diff_y1, diff_x2, diff_y2;
  logic signed [CORNER_W-1:0] c_x1, c_y1, c_x2, c_y2, lim_x, lim_y, r_x2, r_y2;
  logic [2:0]       tag_emit;
  logic [6:0]       tag_class [3];
  logic [31:0]      tag_score [3];
  logic [15:0]      left, top;
  logic [16:0]      right, bottom;
  logic [OUT_DATA_W-1:0] push_data;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = pending < CNT_W'(OUT_DEPTH);
  assign drop          = row_end.valid && !row_end.emit;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCORE_THRESHOLD: cfg.score_threshold <= cfg_data[16:0];
        REG_MIN_BOX_SIZE:    cfg.min_box_size    <= cfg_data[30:0];
        REG_MAX_BOX_SIZE:    cfg.max_box_size    <= cfg_data[30:0];
        REG_MAP_SCALE:       cfg.map_scale       <= cfg_data[23:0];
        REG_PAD_X:           cfg.pad_x           <= $signed(cfg_data);
        REG_PAD_Y:           cfg.pad_y           <= $signed(cfg_data);
        REG_IMAGE_WIDTH:     cfg.image_width     <= cfg_data[13:0];
        REG_IMAGE_HEIGHT:    cfg.image_height    <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  dad_row_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .value      ($signed(s_axis_tdata)),
    .last       (s_axis_tlast),
    .cfg        (cfg),
    .end_accept (end_accept),
    .row_end    (row_end),
    .diff_x1    (diff_x1),
    .diff_y1    (diff_y1),
    .diff_x2    (diff_x2),
    .diff_y2    (diff_y2)
  );

  dad_corner_map u_map_x1 (.clk(clk), .diff(diff_x1), .scale(cfg.map_scale), .corner(c_x1));
  dad_corner_map u_map_y1 (.clk(clk), .diff(diff_y1), .scale(cfg.map_scale), .corner(c_y1));
  dad_corner_map u_map_x2 (.clk(clk), .diff(diff_x2), .scale(cfg.map_scale), .corner(c_x2));
  dad_corner_map u_map_y2 (.clk(clk), .diff(diff_y2), .scale(cfg.map_scale), .corner(c_y2));

  // row-end tags follow the three corner stages
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_emit <= '0;
    end else begin
      tag_emit <= {tag_emit[1:0], row_end.emit};
    end
    tag_class[0] <= row_end.class_index;
    tag_score[0] <= row_end.score;
    tag_class[1] <= tag_class[0];
    tag_score[1] <= tag_score[0];
    tag_class[2] <= tag_class[1];
    tag_score[2] <= tag_score[1];
  end

  assign lim_x = $signed({(CORNER_W - 14)'(0), cfg.image_width});
  assign lim_y = $signed({(CORNER_W - 14)'(0), cfg.image_height});
  assign r_x2  = (c_x2 >= lim_x) ? lim_x - CORNER_W'(1) : c_x2;
  assign r_y2  = (c_y2 >= lim_y) ? lim_y - CORNER_W'(1) : c_y2;

  always_comb begin
    if (c_x1 < 0) begin
      left = '0;
    end else if (c_x1 > CORNER_W'(65535)) begin
      left = 16'hFFFF;
    end else begin
      left = c_x1[15:0];
    end
    if (c_y1 < 0) begin
      top = '0;
    end else if (c_y1 > CORNER_W'(65535)) begin
      top = 16'hFFFF;
    end else begin
      top = c_y1[15:0];
    end
    if (r_x2 < -CORNER_W'(65536)) begin
      right = 17'h10000;
    end else if (r_x2 > CORNER_W'(65535)) begin
      right = 17'h0FFFF;
    end else begin
      right = r_x2[16:0];
    end
    if (r_y2 < -CORNER_W'(65536)) begin
      bottom = 17'h10000;
    end else if (r_y2 > CORNER_W'(65535)) begin
      bottom = 17'h0FFFF;
    end else begin
      bottom = r_y2[16:0];
    end
  end

  assign push_data = {7'b0, tag_score[2], tag_class[2], bottom, right, top, left};

  dad_out_queue #(
    .WIDTH (OUT_DATA_W),
    .DEPTH (OUT_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (tag_emit[2]),
    .push_data (push_data),
    .tvalid    (m_axis_tvalid),
    .tready    (m_axis_tready),
    .tdata     (m_axis_tdata)
  );

  // closed rows not yet dropped or delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CNT_W'(end_accept) - CNT_W'(drop) - CNT_W'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(OUT_DEPTH))
    else $error("pending row count above queue depth");

  a_out_has_credit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != '0)
    else $error("detection shown with no pending row");

  a_row_end_credit: assert property (@(posedge clk) disable iff (rst)
    row_end.valid |-> pending != '0)
    else $error("row decision with no pending row");
`endif

endmodule

FILE: rtl/dad_row_accum.sv
// Row accumulation: box field capture, class score product and running best.
// Produces one row-end record per closed row plus the four corner sums.
// Depends on dad_pkg.
module dad_row_accum import dad_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic signed [31:0]       value,
  input  logic                     last,
  input  cfg_t                     cfg,
  output logic                     end_accept,
  output row_end_t                 row_end,
  output logic signed [DIFF_W-1:0] diff_x1,
  output logic signed [DIFF_W-1:0] diff_y1,
  output logic signed [DIFF_W-1:0] diff_x2,
  output logic signed [DIFF_W-1:0] diff_y2
);

  logic [7:0]         pos;
  logic signed [31:0] cx, cy, w, h, obj;

  logic               p1_cls_ok, p1_end, p1_box_ok;
  logic signed [31:0] p1_val, p1_obj, p1_cx, p1_cy, p1_w, p1_h;
  logic [6:0]         p1_cls;

  logic               p2_cls_ok, p2_end, p2_box_ok;
  logic signed [63:0] p2_prod;
  logic [6:0]         p2_cls;
  logic signed [DIFF_W-1:0] p2_dx1, p2_dy1, p2_dx2, p2_dy2;

  logic signed [31:0] best;
  logic [6:0]         best_class;

  logic               is_box, cls_ok, box_ok, upd;
  logic [7:0]         class_off;
  logic signed [31:0] thr_s, min_s, max_s, prod_sat, fin_best;
  logic [6:0]         fin_class;
  logic signed [DIFF_W-1:0] cx_e, cy_e, w_e, h_e, px_e, py_e;

  assign is_box     = pos < FIRST_CLASS_POS;
  assign class_off  = pos - FIRST_CLASS_POS;
  assign cls_ok     = !is_box && ({1'b0, class_off} < 9'(MaxClasses));
  assign end_accept = accept && last && !is_box;

  assign thr_s = $signed({15'b0, cfg.score_threshold});
  assign min_s = $signed({1'b0, cfg.min_box_size});
  assign max_s = $signed({1'b0, cfg.max_box_size});
  assign box_ok = !(obj < thr_s) && !(w < min_s) && !(h < min_s) &&
                  !(w > max_s) && !(h > max_s);

  // product >> 16 floors; saturate to 32 bits
  always_comb begin
    if (p2_prod[63:47] == {17{p2_prod[63]}}) begin
      prod_sat = p2_prod[47:16];
    end else if (p2_prod[63]) begin
      prod_sat = 32'sh8000_0000;
    end else begin
      prod_sat = 32'sh7FFF_FFFF;
    end
  end

  assign upd       = p2_cls_ok && (prod_sat > best);
  assign fin_best  = upd ? prod_sat : best;
  assign fin_class = upd ? p2_cls : best_class;

  assign cx_e = DIFF_W'(p1_cx);
  assign cy_e = DIFF_W'(p1_cy);
  assign w_e  = DIFF_W'(p1_w);
  assign h_e  = DIFF_W'(p1_h);
  assign px_e = DIFF_W'(cfg.pad_x);
  assign py_e = DIFF_W'(cfg.pad_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      cx         <= '0;
      cy         <= '0;
      w          <= '0;
      h          <= '0;
      obj        <= '0;
      p1_cls_ok  <= 1'b0;
      p1_end     <= 1'b0;
      p2_cls_ok  <= 1'b0;
      p2_end     <= 1'b0;
      best       <= SCORE_INIT;
      best_class <= '0;
      row_end    <= '0;
    end else begin
      p1_cls_ok <= accept && cls_ok;
      p1_end    <= end_accept;
      if (accept) begin
        p1_val <= value;
        p1_obj <= obj;
        p1_cls <= class_off[6:0];
        if (last) begin
          p1_box_ok <= box_ok;
          p1_cx     <= cx;
          p1_cy     <= cy;
          p1_w      <= w;
          p1_h      <= h;
          pos       <= '0;
          cx        <= '0;
          cy        <= '0;
          w         <= '0;
          h         <= '0;
          obj       <= '0;
        end else begin
          if (pos != POS_MAX) begin
            pos <= pos + 8'd1;
          end
          if (is_box) begin
            case (pos[2:0])
              3'd0:    cx  <= value;
              3'd1:    cy  <= value;
              3'd2:    w   <= value;
              3'd3:    h   <= value;
              default: obj <= value;
            endcase
          end
        end
      end

      p2_cls_ok <= p1_cls_ok;
      p2_end    <= p1_end;
      p2_prod   <= p1_val * p1_obj;
      p2_cls    <= p1_cls;
      p2_box_ok <= p1_box_ok;
      p2_dx1    <= (cx_e <<< 1) - w_e - (px_e <<< 1);
      p2_dx2    <= (cx_e <<< 1) + w_e - (px_e <<< 1);
      p2_dy1    <= (cy_e <<< 1) - h_e - (py_e <<< 1);
      p2_dy2    <= (cy_e <<< 1) + h_e - (py_e <<< 1);

      row_end.valid       <= p2_end;
      row_end.emit        <= p2_end && p2_box_ok && !(fin_best < thr_s);
      row_end.class_index <= fin_class;
      row_end.score       <= fin_best;
      diff_x1 <= p2_dx1;
      diff_x2 <= p2_dx2;
      diff_y1 <= p2_dy1;
      diff_y2 <= p2_dy2;

      if (p2_end) begin
        best       <= SCORE_INIT;
        best_class <= '0;
      end else if (upd) begin
        best       <= prod_sat;
        best_class <= p2_cls;
      end
    end
  end

endmodule

FILE: rtl/dad_corner_map.sv
// Corner mapping: scales a corner sum by map_scale and divides by 2^33,
// truncating toward zero. Three register stages. Depends on dad_pkg.
module dad_corner_map import dad_pkg::*; (
  input  logic                       clk,
  input  logic signed [DIFF_W-1:0]   diff,
  input  logic [SCALE_W-1:0]         scale,
  output logic signed [CORNER_W-1:0] corner
);

  logic                     neg1, neg2;
  logic [MAG_W-1:0]         mag;
  logic [LO_W+SCALE_W-1:0]  lo_p;
  logic [HI_W+SCALE_W-1:0]  hi_p;
  logic signed [DIFF_W-1:0] diff_abs;
  logic [SUM_W-1:0]         sum;
  logic [QUOT_W-1:0]        quot;

  assign diff_abs = diff[DIFF_W-1] ? -diff : diff;
  assign sum      = {hi_p, LO_W'(0)} + SUM_W'(lo_p);
  assign quot     = sum[SUM_W-1:MAP_SHIFT];

  always_ff @(posedge clk) begin
    neg1   <= diff[DIFF_W-1];
    mag    <= diff_abs[MAG_W-1:0];
    neg2   <= neg1;
    lo_p   <= mag[LO_W-1:0] * scale;
    hi_p   <= mag[MAG_W-1:LO_W] * scale;
    corner <= neg2 ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

endmodule

FILE: rtl/dad_out_queue.sv
// Output queue for finished detections, master stream side.
// Register array with head read; no dependencies beyond parameters.
module dad_out_queue #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             tvalid,
  input  logic             tready,
  output logic [WIDTH-1:0] tdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign tvalid = count != '0;
  assign tdata  = mem[rd_ptr];
  assign pop    = tvalid && tready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule
